// ===== hw/rtl/pfa_pkg.sv =====
// Shared types, constants and the pair-kind map of the pair force accumulator.
// Depends on nothing; the rest of hw/rtl imports it, apart from pfa_out_if.
package pfa_pkg;

  localparam int unsigned NUM_TYPES = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned TYPE_W    = $clog2(NUM_TYPES);
  localparam int unsigned B_W       = FRAC_BITS + 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] KIND_WLJ  = 2'd0;
  localparam logic [1:0] KIND_SLJ  = 2'd1;
  localparam logic [1:0] KIND_WREP = 2'd2;
  localparam logic [1:0] KIND_SREP = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WEAK_LJ    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_LJ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_REP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_REP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SQ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIMIT  = 3'd5;

  // symmetric type map
  function automatic logic [1:0] pair_kind(input logic [TYPE_W-1:0] a,
                                           input logic [TYPE_W-1:0] b);
    logic [1:0] k;
    k = KIND_WREP;
    if (a == 2'd0 && b == 2'd0) k = KIND_WLJ;
    else if ((a == 2'd0 && b == 2'd2) || (a == 2'd2 && b == 2'd0)) k = KIND_WLJ;
    else if ((a == 2'd0 && b == 2'd1) || (a == 2'd1 && b == 2'd0)) k = KIND_SLJ;
    else if (a == 2'd1 && b == 2'd1) k = KIND_SREP;
    return k;
  endfunction

endpackage

// ===== hw/rtl/pfa_if.sv =====
// Channel interfaces of the pair force accumulator: neighbour, result, config.
// Depends on pfa_pkg.
interface pfa_in_if import pfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [TYPE_W-1:0]  own_type;
  logic [TYPE_W-1:0]  nbr_type;
  logic [15:0]        self_mass;
  logic               skip;
  logic               last;
  modport source (output valid, dx, dy, own_type, nbr_type, self_mass, skip, last,
                  input ready);
  modport sink   (input valid, dx, dy, own_type, nbr_type, self_mass, skip, last,
                  output ready);
endinterface

interface pfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  modport source (output valid, accel_x, accel_y, input ready);
  modport sink   (input valid, accel_x, accel_y, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pair_force_accumulator.sv =====
// Pair force accumulator: one shared 32x32 multiplier and one shared iterative
// divide / square-root unit under a sequencer. A neighbour word in range runs
// a 32-step square root and up to four 64-step divisions, a skipped one none;
// a last word adds a clamp of up to one more root and two more divisions. A new
// word is taken only in the idle state. Reset (async, active low) clears state,
// config, sums and the result valid; no clearing pass is needed.
module pair_force_accumulator import pfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfa_cfg_if.sink    cfg_i,
  pfa_in_if.sink     nbr_i,
  pfa_out_if.source  acc_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_CHK, S_RT, S_DB, S_B2, S_B4, S_REP, S_FM1, S_FM2,
    S_FL, S_DA, S_CX, S_DX, S_CY, S_DY, S_FIN, S_OX, S_OY, S_OL, S_ORT,
    S_OMX, S_ODX, S_OMY, S_ODY, S_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0] kparam_q [4];
  logic [30:0] range_sq_q, acc_lim_q;

  // latched word
  logic [31:0] adx_q, ady_q;
  logic        sx_q, sy_q, last_q;
  logic [1:0]  kind_q;
  logic [15:0] mass_q;

  // working values
  logic [31:0]    dist_q;
  logic [B_W-1:0] b_q;
  logic [31:0]    b2_q, amag_q;
  logic [46:0]    dmag_q;
  logic           fneg_q;
  logic [53:0]    fmag_q;
  logic [63:0]    prod_q;
  logic signed [31:0] sum_x_q, sum_y_q, ox_q, oy_q, out_x_q, out_y_q;
  logic           out_vld_q;

  // shared iterative unit: num holds dividend/quotient or radicand
  logic [63:0] num_q, acc_q, bit_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [31:0] kp, abs_sx, abs_sy;
  logic [15:0] strength, dpar;

  assign kp       = kparam_q[kind_q];
  assign strength = kp[31:16];
  assign dpar     = kp[15:0];
  assign abs_sx   = sum_x_q[31] ? (~sum_x_q + 32'd1) : sum_x_q;
  assign abs_sy   = sum_y_q[31] ? (~sum_y_q + 32'd1) : sum_y_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQX: begin mul_a = adx_q; mul_b = adx_q; end
      S_SQY: begin mul_a = ady_q; mul_b = ady_q; end
      S_B2:  begin mul_a = 32'(b_q); mul_b = 32'(b_q); end
      S_B4:  begin mul_a = b2_q; mul_b = b2_q; end
      S_FM1: begin mul_a = 32'(dmag_q[23:0]); mul_b = 32'(strength); end
      S_FM2: begin mul_a = 32'(dmag_q[46:24]); mul_b = 32'(strength); end
      S_FL:  begin mul_a = 32'(acc_lim_q); mul_b = 32'(mass_q); end
      S_CX:  begin mul_a = amag_q; mul_b = adx_q; end
      S_CY:  begin mul_a = amag_q; mul_b = ady_q; end
      S_OX:  begin mul_a = abs_sx; mul_b = abs_sx; end
      S_OY:  begin mul_a = abs_sy; mul_b = abs_sy; end
      S_OL:  begin mul_a = 32'(acc_lim_q); mul_b = 32'(acc_lim_q); end
      S_OMX: begin mul_a = abs_sx; mul_b = 32'(acc_lim_q); end
      S_OMY: begin mul_a = abs_sy; mul_b = 32'(acc_lim_q); end
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // one restoring divide step
  logic [32:0] dv_t, dv_r;
  logic        dv_ge;
  assign dv_t  = {acc_q[31:0], num_q[63]};
  assign dv_ge = dv_t >= {1'b0, den_q};
  assign dv_r  = dv_ge ? (dv_t - {1'b0, den_q}) : dv_t;

  // one square-root step
  logic [63:0] rt_sum;
  logic        rt_ge;
  assign rt_sum = acc_q + bit_q;
  assign rt_ge  = num_q >= rt_sum;

  // Lennard-Jones and repulsion differences
  logic [47:0]        b4_raw;
  logic [46:0]        b4;
  logic signed [48:0] lj_d;
  logic signed [25:0] rep_d;
  assign b4_raw = mul_p[63:16];
  assign b4     = (b4_raw > 48'(64'd1 << 46)) ? 47'(64'd1 << 46) : b4_raw[46:0];
  assign lj_d   = $signed({2'b00, b4}) - $signed({16'b0, b2_q, 1'b0});
  assign rep_d  = $signed({2'b00, b_q}) - $signed(26'(64'd1 << FRAC_BITS));

  // force magnitude and floor
  logic [63:0] fm_full;
  logic [55:0] fm_sh;
  logic [38:0] fl;
  logic [53:0] fnew;
  assign fm_full = (mul_p << 24) + prod_q;
  assign fm_sh   = fm_full[63:8];
  assign fl      = mul_p[46:8];
  assign fnew    = (fneg_q && fmag_q > 54'(fl)) ? 54'(fl) : fmag_q;

  // saturating accumulate
  logic signed [33:0] add_x, add_y;
  logic               nx, ny;
  assign nx    = sx_q != fneg_q;
  assign ny    = sy_q != fneg_q;
  assign add_x = 34'(sum_x_q) + (nx ? -$signed({2'b0, num_q[31:0]})
                                    : $signed({2'b0, num_q[31:0]}));
  assign add_y = 34'(sum_y_q) + (ny ? -$signed({2'b0, num_q[31:0]})
                                    : $signed({2'b0, num_q[31:0]}));

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -34'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign nbr_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready  = 1'b1;
  assign acc_o.valid  = out_vld_q;
  assign acc_o.accel_x = out_x_q;
  assign acc_o.accel_y = out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kparam_q    <= '{default: '0};
      range_sq_q  <= '0;
      acc_lim_q   <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_vld_q   <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_WEAK_LJ:    kparam_q[0] <= cfg_i.data;
          REG_STRONG_LJ:  kparam_q[1] <= cfg_i.data;
          REG_WEAK_REP:   kparam_q[2] <= cfg_i.data;
          REG_STRONG_REP: kparam_q[3] <= cfg_i.data;
          REG_RANGE_SQ:   range_sq_q  <= cfg_i.data[30:0];
          REG_ACC_LIMIT:  acc_lim_q   <= cfg_i.data[30:0];
          default: ; // drop writes beyond the register list
        endcase
      end
      // drop the result once taken, unless a new one is loaded in this cycle
      if (acc_o.valid && acc_o.ready && state_q != S_EMIT) out_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: if (nbr_i.valid) begin
          adx_q  <= nbr_i.dx[31] ? (~nbr_i.dx + 32'd1) : nbr_i.dx;
          ady_q  <= nbr_i.dy[31] ? (~nbr_i.dy + 32'd1) : nbr_i.dy;
          sx_q   <= nbr_i.dx[31];
          sy_q   <= nbr_i.dy[31];
          kind_q <= pair_kind(nbr_i.own_type, nbr_i.nbr_type);
          mass_q <= (nbr_i.self_mass == 16'd0) ? 16'd1 : nbr_i.self_mass;
          last_q <= nbr_i.last;
          state_q <= nbr_i.skip ? S_FIN : S_SQX;
        end
        S_SQX: begin prod_q <= mul_p; state_q <= S_SQY; end
        S_SQY: begin prod_q <= prod_q + mul_p; state_q <= S_CHK; end
        S_CHK: begin
          if (prod_q == 64'd0 || prod_q > (64'(range_sq_q) << FRAC_BITS)) begin
            state_q <= S_FIN;
          end else begin
            num_q <= prod_q; acc_q <= '0; bit_q <= 64'd1 << 62; cnt_q <= 7'd32;
            state_q <= S_RT;
          end
        end
        S_RT: begin
          if (cnt_q != 7'd0) begin
            if (rt_ge) begin
              num_q <= num_q - rt_sum; acc_q <= (acc_q >> 1) + bit_q;
            end else begin
              acc_q <= acc_q >> 1;
            end
            bit_q <= bit_q >> 2;
            cnt_q <= cnt_q - 7'd1;
          end else if (acc_q[31:0] == 32'd0) begin
            state_q <= S_FIN;
          end else begin
            dist_q <= acc_q[31:0];
            den_q  <= acc_q[31:0];
            num_q  <= 64'(dpar) << (2 * FRAC_BITS - 8);
            acc_q  <= '0; cnt_q <= 7'd64;
            state_q <= S_DB;
          end
        end
        S_DB: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            b_q <= (num_q >= 64'(1 << B_W)) ? {B_W{1'b1}} : num_q[B_W-1:0];
            state_q <= (kind_q == KIND_WLJ || kind_q == KIND_SLJ) ? S_B2 : S_REP;
          end
        end
        S_B2: begin b2_q <= mul_p[47:16]; state_q <= S_B4; end
        S_B4: begin
          fneg_q <= lj_d[48];
          dmag_q <= lj_d[48] ? 47'(-lj_d) : lj_d[46:0];
          state_q <= S_FM1;
        end
        S_REP: begin
          fneg_q <= rep_d[25];
          dmag_q <= rep_d[25] ? 47'(-rep_d) : 47'(rep_d);
          state_q <= S_FM1;
        end
        S_FM1: begin prod_q <= mul_p; state_q <= S_FM2; end
        S_FM2: begin
          fmag_q <= (fm_sh > 56'((64'd1 << 54) - 1)) ? {54{1'b1}} : fm_sh[53:0];
          state_q <= S_FL;
        end
        S_FL: begin
          if (fnew == 54'd0) begin
            state_q <= S_FIN;
          end else begin
            num_q <= 64'(fnew) << 8; den_q <= 32'(mass_q);
            acc_q <= '0; cnt_q <= 7'd64;
            state_q <= S_DA;
          end
        end
        S_DA: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            amag_q <= (num_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : num_q[31:0];
            state_q <= S_CX;
          end
        end
        S_CX: begin
          num_q <= mul_p; den_q <= dist_q; acc_q <= '0; cnt_q <= 7'd64;
          state_q <= S_DX;
        end
        S_DX: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            sum_x_q <= sat32(add_x);
            state_q <= S_CY;
          end
        end
        S_CY: begin
          num_q <= mul_p; den_q <= dist_q; acc_q <= '0; cnt_q <= 7'd64;
          state_q <= S_DY;
        end
        S_DY: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            sum_y_q <= sat32(add_y);
            state_q <= S_FIN;
          end
        end
        S_FIN: state_q <= last_q ? S_OX : S_IDLE;
        // clamp the sum to the acceleration limit
        S_OX: begin prod_q <= mul_p; state_q <= S_OY; end
        S_OY: begin prod_q <= prod_q + mul_p; state_q <= S_OL; end
        S_OL: begin
          if (prod_q > mul_p) begin
            num_q <= prod_q; acc_q <= '0; bit_q <= 64'd1 << 62; cnt_q <= 7'd32;
            state_q <= S_ORT;
          end else begin
            ox_q <= sum_x_q; oy_q <= sum_y_q;
            state_q <= S_EMIT;
          end
        end
        S_ORT: begin
          if (cnt_q != 7'd0) begin
            if (rt_ge) begin
              num_q <= num_q - rt_sum; acc_q <= (acc_q >> 1) + bit_q;
            end else begin
              acc_q <= acc_q >> 1;
            end
            bit_q <= bit_q >> 2;
            cnt_q <= cnt_q - 7'd1;
          end else begin
            dist_q <= (acc_q[31:0] == 32'd0) ? 32'd1 : acc_q[31:0];
            state_q <= S_OMX;
          end
        end
        S_OMX: begin
          num_q <= mul_p; den_q <= dist_q; acc_q <= '0; cnt_q <= 7'd64;
          state_q <= S_ODX;
        end
        S_ODX: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            ox_q <= sum_x_q[31] ? -$signed(num_q[31:0]) : $signed(num_q[31:0]);
            state_q <= S_OMY;
          end
        end
        S_OMY: begin
          num_q <= mul_p; den_q <= dist_q; acc_q <= '0; cnt_q <= 7'd64;
          state_q <= S_ODY;
        end
        S_ODY: begin
          if (cnt_q != 7'd0) begin
            acc_q <= 64'(dv_r[31:0]); num_q <= {num_q[62:0], dv_ge};
            cnt_q <= cnt_q - 7'd1;
          end else begin
            oy_q <= sum_y_q[31] ? -$signed(num_q[31:0]) : $signed(num_q[31:0]);
            state_q <= S_EMIT;
          end
        end
        // hold until the result register is free, then clear the sums
        S_EMIT: if (!out_vld_q || acc_o.ready) begin
          out_x_q   <= ox_q;
          out_y_q   <= oy_q;
          out_vld_q <= 1'b1;
          sum_x_q   <= '0;
          sum_y_q   <= '0;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
